// ===== rtl/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// Shared constants and codes of the piecewise-linear calibration unit.
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

  localparam int unsigned NUM_POINTS_DEF  = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  // request kinds carried in the slave-side tuser
  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_APPEND  = 2'd1,
    REQ_CONVERT = 2'd2
  } req_e;

  // result status carried in the master-side tuser
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_FEW     = 2'd2,
    STAT_ZERO_DX = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/plc_table.sv =====
// ----------------------------------------------------------------------------
// plc_table
// Calibration point memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_table #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned ADDR_W = 3,
  parameter int unsigned DATA_W = 42
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/plc_div.sv =====
// ----------------------------------------------------------------------------
// plc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_div #(
  parameter int unsigned NUM_W = 43,
  parameter int unsigned DEN_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic             done_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== rtl/piecewise_linear_calibration_unit.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_calibration_unit
// Calibration point table with piecewise-linear sample conversion.
// ----------------------------------------------------------------------------
// Input beats arrive on s_axis: tuser carries the request (clear, append,
// convert), tdata the point to append and the sample to convert. Every input
// beat yields exactly one output beat on m_axis: tdata is the converted value
// (signed Q16.16, saturated, zero unless a conversion succeeds), tuser the
// status.
// One item is in work at a time; s_axis_tready is low until its result has
// been moved into the output register. Clear and append go from acceptance
// through S_OUT to a valid output beat. A conversion walks the table on the
// single memory port (S_SCAN_RD and S_SCAN_CHK per point visited), fetches
// the chosen segment (S_LO_RD, S_LO_GET, S_HI_RD, S_HI_GET), multiplies
// (S_MUL), then runs the bit-serial divider, one quotient bit per cycle,
// and saturates the sum (S_SUM) before S_OUT. A stalled receiver holds the
// output beat; the next item is taken meanwhile and its result waits until
// the output register frees up.
// Reset empties the table (point count zero) and clears the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_calibration_unit
  import plc_pkg::*;
#(
  parameter int unsigned NUM_POINTS  = NUM_POINTS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int unsigned S_DATA_W   = ((2 * SAMPLE_BITS + 32) + 7) / 8 * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // point_analog, point_value, sample (low bit up), zero padded
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // value
  output logic [31:0]         m_axis_tdata,
  // status
  output logic [1:0]          m_axis_tuser
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned IW  = $clog2(NUM_POINTS);
  localparam int unsigned CW  = $clog2(NUM_POINTS + 1);
  localparam int unsigned EW  = SB + 32;
  localparam int unsigned PW  = SB + 34;
  localparam int unsigned MW  = SB + 33;
  localparam int unsigned SW  = MW + 2;
  localparam logic signed [SW-1:0] SUM_MAX = SW'(32'sh7fff_ffff);
  localparam logic signed [SW-1:0] SUM_MIN = SW'(32'sh8000_0000);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_LO_RD,
    S_LO_GET,
    S_HI_RD,
    S_HI_GET,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SUM,
    S_OUT
  } state_e;

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [IW-1:0]          idx_q, idx_d;
  logic [SB-1:0]          sample_q, sample_d;
  logic [SB-1:0]          prev_q, prev_d;
  logic [SB-1:0]          x0_q, x0_d;
  logic signed [31:0]     y0_q, y0_d;
  logic signed [SB:0]     dx_q, dx_d;
  logic signed [32:0]     dy_q, dy_d;
  logic signed [SB:0]     diff_q, diff_d;
  logic signed [PW-1:0]   prod_q, prod_d;
  logic                   neg_q, neg_d;
  logic [31:0]            res_value_q, res_value_d;
  status_e                res_status_q, res_status_d;
  logic                   m_valid_q, m_valid_d;
  logic [31:0]            m_data_q, m_data_d;
  logic [1:0]             m_user_q, m_user_d;

  logic                   accept;
  logic                   is_full;
  logic                   tbl_we;
  logic [IW-1:0]          last_idx;
  logic [IW-1:0]          tail_lo;
  logic [SB-1:0]          in_analog;
  logic [31:0]            in_value;
  logic [SB-1:0]          in_sample;
  logic [EW-1:0]          rd_data;
  logic [SB-1:0]          rd_x;
  logic [31:0]            rd_y;
  logic                   div_start;
  logic [MW-1:0]          div_num;
  logic [SB-1:0]          div_den;
  logic [MW-1:0]          div_quo;
  logic                   div_done;
  logic signed [SW-1:0]   q_ext;
  logic signed [SW-1:0]   q_signed;
  logic signed [SW-1:0]   sum;

  assign in_analog = s_axis_tdata[SB-1:0];
  assign in_value  = s_axis_tdata[SB+31:SB];
  assign in_sample = s_axis_tdata[2*SB+31:SB+32];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign is_full       = (count_q == CW'(NUM_POINTS));
  assign tbl_we        = accept && (req_e'(s_axis_tuser) == REQ_APPEND) && !is_full;
  assign last_idx      = IW'(count_q - CW'(1));
  assign tail_lo       = IW'(count_q - CW'(2));

  assign rd_x = rd_data[SB-1:0];
  assign rd_y = rd_data[EW-1:SB];

  plc_table #(
    .DEPTH  (NUM_POINTS),
    .ADDR_W (IW),
    .DATA_W (EW)
  ) u_plc_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (IW'(count_q)),
    .wdata_i ({in_value, in_analog}),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // divide magnitudes; the sign is put back afterwards (truncation toward zero)
  assign div_start = (state_q == S_DIV_GO);
  assign div_num   = prod_q[PW-1] ? MW'(-prod_q) : MW'(prod_q);
  assign div_den   = dx_q[SB] ? SB'(-dx_q) : SB'(dx_q);

  plc_div #(
    .NUM_W (MW),
    .DEN_W (SB)
  ) u_plc_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  assign q_ext    = {2'b00, div_quo};
  assign q_signed = neg_q ? -q_ext : q_ext;
  assign sum      = q_signed + SW'(y0_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    sample_d     = sample_q;
    prev_d       = prev_q;
    x0_d         = x0_q;
    y0_d         = y0_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    diff_d       = diff_q;
    prod_d       = prod_q;
    neg_d        = neg_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;

    // retire the output beat once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_value_d  = '0;
          res_status_d = STAT_OK;
          state_d      = S_OUT;
          case (req_e'(s_axis_tuser))
            REQ_CLEAR: begin
              count_d = '0;
            end
            REQ_APPEND: begin
              if (is_full) begin
                res_status_d = STAT_FULL;
              end else begin
                count_d = count_q + CW'(1);
              end
            end
            REQ_CONVERT: begin
              sample_d = in_sample;
              if (count_q < CW'(2)) begin
                res_status_d = STAT_FEW;
              end else begin
                idx_d   = '0;
                state_d = S_SCAN_RD;
              end
            end
            default: begin
              res_status_d = STAT_OK;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (idx_q == '0) begin
          if (sample_q < rd_x) begin
            // below the table: extrapolate along the first segment
            state_d = S_LO_RD;
          end else begin
            prev_d  = rd_x;
            idx_d   = idx_q + IW'(1);
            state_d = S_SCAN_RD;
          end
        end else if (prev_q <= sample_q && sample_q < rd_x) begin
          idx_d   = idx_q - IW'(1);
          state_d = S_LO_RD;
        end else if (idx_q == last_idx) begin
          // above the table: extrapolate along the last segment
          idx_d   = tail_lo;
          state_d = S_LO_RD;
        end else begin
          prev_d  = rd_x;
          idx_d   = idx_q + IW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_LO_RD: begin
        state_d = S_LO_GET;
      end
      S_LO_GET: begin
        x0_d    = rd_x;
        y0_d    = rd_y;
        idx_d   = idx_q + IW'(1);
        state_d = S_HI_RD;
      end
      S_HI_RD: begin
        state_d = S_HI_GET;
      end
      S_HI_GET: begin
        dx_d   = $signed({1'b0, rd_x}) - $signed({1'b0, x0_q});
        dy_d   = $signed({rd_y[31], rd_y}) - $signed({y0_q[31], y0_q});
        diff_d = $signed({1'b0, sample_q}) - $signed({1'b0, x0_q});
        if (rd_x == x0_q) begin
          res_status_d = STAT_ZERO_DX;
          state_d      = S_OUT;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = PW'(dy_q) * PW'(diff_q);
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        neg_d   = prod_q[PW-1] ^ dx_q[SB];
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (sum > SUM_MAX) begin
          res_value_d = 32'h7fff_ffff;
        end else if (sum < SUM_MIN) begin
          res_value_d = 32'h8000_0000;
        end else begin
          res_value_d = sum[31:0];
        end
        res_status_d = STAT_OK;
        state_d      = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = res_value_q;
          m_user_d  = res_status_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q     <= sample_d;
    prev_q       <= prev_d;
    x0_q         <= x0_d;
    y0_q         <= y0_d;
    dx_q         <= dx_d;
    dy_q         <= dy_d;
    diff_q       <= diff_d;
    prod_q       <= prod_d;
    neg_q        <= neg_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

// ===== rtl/plc_checker.sv =====
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks of the calibration unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_checker
  import plc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int unsigned S_DATA_W   = ((2 * SAMPLE_BITS + 32) + 7) / 8 * 8
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [S_DATA_W-1:0] s_axis_tdata,
  input logic [1:0]          s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [31:0]         m_axis_tdata,
  input logic [1:0]          m_axis_tuser
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // every failed result (status other than OK) carries a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> (m_axis_tdata == 32'd0))
    else $error("error status with nonzero value");

  // with no beat pending at acceptance, no result shows up in the cycle right after it
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind piecewise_linear_calibration_unit plc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_plc_checker (.*);

`default_nettype wire
